FILE: design/gbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro bias calibration package
// Widths, constants, register indexes and pipeline control types shared by
// the gyro bias calibration modules.
// ----------------------------------------------------------------------------
package gbc_pkg;

	localparam int WINDOW   = 128;
	localparam int WIN_LOG  = $clog2(WINDOW);
	localparam int IDX_W    = WIN_LOG;
	localparam int WIN_W    = WIN_LOG + 1;
	localparam int WIN_SQ_W = 2 * WIN_W;

	localparam int SAMPLE_W = 16;
	localparam int DELTA_W  = SAMPLE_W + 1;
	localparam int SQ_W     = 2 * SAMPLE_W - 1;
	localparam int SUM_W    = SAMPLE_W + WIN_LOG;
	localparam int SQSUM_W  = SQ_W + WIN_LOG;
	localparam int PROD_W   = SQSUM_W + WIN_LOG;
	localparam int QW_W     = SAMPLE_W + WIN_W;
	localparam int ROW_W    = 3 * SAMPLE_W;

	localparam int THR_W      = 20;
	localparam int SETTLE_W   = 16;
	localparam int CNT_W      = SETTLE_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = THR_W;

	localparam logic [WIN_W-1:0]    WIN_C    = WIN_W'(WINDOW);
	localparam logic [WIN_SQ_W-1:0] WIN_SQ_C = WIN_SQ_W'(WINDOW * WINDOW);
	localparam logic [SUM_W-1:0]    RECIP_M  = SUM_W'((64'd1 << SUM_W) / WINDOW);
	localparam logic [IDX_W-1:0]    IDX_LAST = IDX_W'(WINDOW - 1);

	localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(5);
	localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(99);

	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VAR_THRESHOLD  = 2'd0,
		REG_SETTLE_SAMPLES = 2'd1
	} gbc_reg_t;

	typedef struct packed {
		logic accept;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
		logic ld_s6;
		logic ld_out;
	} gbc_pipe_t;

endpackage

FILE: design/gbc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro bias calibration channels
// Valid/ready interfaces for gyro samples, corrected results and register
// writes.
// ----------------------------------------------------------------------------
interface gbc_sample_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [gbc_pkg::SAMPLE_W-1:0]    gyro_x;
	logic signed [gbc_pkg::SAMPLE_W-1:0]    gyro_y;
	logic signed [gbc_pkg::SAMPLE_W-1:0]    gyro_z;

	modport source (output valid, output gyro_x, output gyro_y, output gyro_z, input ready);
	modport sink (input valid, input gyro_x, input gyro_y, input gyro_z, output ready);
endinterface

interface gbc_result_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [gbc_pkg::SAMPLE_W-1:0]    corrected_x;
	logic signed [gbc_pkg::SAMPLE_W-1:0]    corrected_y;
	logic signed [gbc_pkg::SAMPLE_W-1:0]    corrected_z;
	logic                                   offset_updated;
	logic                                   window_full;

	modport source (output valid, output corrected_x, output corrected_y, output corrected_z,
		output offset_updated, output window_full, input ready);
	modport sink (input valid, input corrected_x, input corrected_y, input corrected_z,
		input offset_updated, input window_full, output ready);
endinterface

interface gbc_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [gbc_pkg::CFG_IDX_W-1:0]          index;
	logic [gbc_pkg::CFG_DATA_W-1:0]         data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/gbc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module gbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/gbc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro bias calibration axis lane
// Running sum and sum of squares for one axis, exact variance test, window
// mean by reciprocal multiply, and offset subtraction with saturation.
// ----------------------------------------------------------------------------
module gbc_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gbc_pkg::gbc_pipe_t                  pipe,
	input  logic signed [gbc_pkg::SAMPLE_W-1:0] sample,
	input  logic signed [gbc_pkg::SAMPLE_W-1:0] old_sample,
	input  logic                                old_valid,
	input  logic [gbc_pkg::THR_W-1:0]           threshold,
	input  logic                                latch,
	output logic                                stationary,
	output logic signed [gbc_pkg::SAMPLE_W-1:0] corrected
);

	// stage 1
	logic signed [gbc_pkg::SAMPLE_W-1:0]   sample_s1;
	logic signed [gbc_pkg::SAMPLE_W-1:0]   old_m;
	logic signed [2*gbc_pkg::SAMPLE_W-1:0] sq_new_full;
	logic signed [2*gbc_pkg::SAMPLE_W-1:0] sq_old_full;
	logic signed [gbc_pkg::DELTA_W-1:0]    delta;

	// stage 2
	logic signed [gbc_pkg::SAMPLE_W-1:0] sample_s2;
	logic signed [gbc_pkg::DELTA_W-1:0]  delta_s2;
	logic [gbc_pkg::SQ_W-1:0]            sq_new_s2;
	logic [gbc_pkg::SQ_W-1:0]            sq_old_s2;

	// running sums
	logic signed [gbc_pkg::SUM_W-1:0] sum_q;
	logic [gbc_pkg::SQSUM_W-1:0]      sumsq_q;

	// stage 3
	logic signed [gbc_pkg::SAMPLE_W-1:0]  sample_s3;
	logic [gbc_pkg::SUM_W-1:0]            abs_sum;
	logic signed [2*gbc_pkg::SUM_W-1:0]   ssq_full;
	logic [2*gbc_pkg::SUM_W-1:0]          recip_prod;
	logic [gbc_pkg::PROD_W-1:0]           nsq;
	logic [gbc_pkg::PROD_W-1:0]           bound;

	// stage 4
	logic signed [gbc_pkg::SAMPLE_W-1:0] sample_s4;
	logic [gbc_pkg::PROD_W-1:0]          nsq_s4;
	logic [gbc_pkg::PROD_W-1:0]          ssq_s4;
	logic [gbc_pkg::PROD_W-1:0]          bound_s4;
	logic [gbc_pkg::SAMPLE_W-1:0]        q_s4;
	logic [gbc_pkg::SUM_W-1:0]           abs_s4;
	logic                                neg_s4;
	logic [gbc_pkg::PROD_W-1:0]          spread;
	logic [gbc_pkg::QW_W-1:0]            qw_full;

	// stage 5
	logic signed [gbc_pkg::SAMPLE_W-1:0] sample_s5;
	logic                                stat_s5;
	logic [gbc_pkg::SUM_W-1:0]           qw_s5;
	logic [gbc_pkg::SAMPLE_W-1:0]        q_s5;
	logic [gbc_pkg::SUM_W-1:0]           abs_s5;
	logic                                neg_s5;
	logic [gbc_pkg::SUM_W-1:0]           rem;
	logic [gbc_pkg::SAMPLE_W-1:0]        q_fix;
	logic signed [gbc_pkg::SAMPLE_W-1:0] mean;

	// stage 6
	logic signed [gbc_pkg::SAMPLE_W-1:0] sample_s6;
	logic                                stat_s6;
	logic signed [gbc_pkg::SAMPLE_W-1:0] mean_s6;
	logic signed [gbc_pkg::SAMPLE_W-1:0] offset_q;
	logic signed [gbc_pkg::SAMPLE_W-1:0] offset_sel;
	logic signed [gbc_pkg::DELTA_W-1:0]  diff;

	always_comb begin
		old_m       = old_valid ? old_sample : '0;
		sq_new_full = sample_s1 * sample_s1;
		sq_old_full = old_m * old_m;
		delta       = gbc_pkg::DELTA_W'(sample_s1) - gbc_pkg::DELTA_W'(old_m);
	end

	always_ff @(posedge clk) begin
		if (pipe.accept) begin
			sample_s1 <= sample;
		end
		if (pipe.ld_s2) begin
			sample_s2 <= sample_s1;
			delta_s2  <= delta;
			sq_new_s2 <= sq_new_full[gbc_pkg::SQ_W-1:0];
			sq_old_s2 <= sq_old_full[gbc_pkg::SQ_W-1:0];
		end
		if (pipe.ld_s3) begin
			sample_s3 <= sample_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			sumsq_q <= '0;
		end else if (pipe.ld_s3) begin
			sum_q   <= sum_q + gbc_pkg::SUM_W'(delta_s2);
			sumsq_q <= sumsq_q + gbc_pkg::SQSUM_W'(sq_new_s2) - gbc_pkg::SQSUM_W'(sq_old_s2);
		end
	end

	always_comb begin
		abs_sum    = sum_q[gbc_pkg::SUM_W-1] ? gbc_pkg::SUM_W'(-sum_q) : gbc_pkg::SUM_W'(sum_q);
		ssq_full   = sum_q * sum_q;
		recip_prod = (2*gbc_pkg::SUM_W)'(abs_sum) * (2*gbc_pkg::SUM_W)'(gbc_pkg::RECIP_M);
		nsq        = gbc_pkg::PROD_W'(sumsq_q) * gbc_pkg::PROD_W'(gbc_pkg::WIN_C);
		bound      = gbc_pkg::PROD_W'(threshold) * gbc_pkg::PROD_W'(gbc_pkg::WIN_SQ_C);
	end

	always_ff @(posedge clk) begin
		if (pipe.ld_s4) begin
			sample_s4 <= sample_s3;
			nsq_s4    <= nsq;
			ssq_s4    <= ssq_full[gbc_pkg::PROD_W-1:0];
			bound_s4  <= bound;
			q_s4      <= recip_prod[gbc_pkg::SUM_W +: gbc_pkg::SAMPLE_W];
			abs_s4    <= abs_sum;
			neg_s4    <= sum_q[gbc_pkg::SUM_W-1];
		end
	end

	always_comb begin
		spread  = nsq_s4 - ssq_s4;
		qw_full = gbc_pkg::QW_W'(q_s4) * gbc_pkg::QW_W'(gbc_pkg::WIN_C);
	end

	always_ff @(posedge clk) begin
		if (pipe.ld_s5) begin
			sample_s5 <= sample_s4;
			stat_s5   <= spread < bound_s4;
			qw_s5     <= qw_full[gbc_pkg::SUM_W-1:0];
			q_s5      <= q_s4;
			abs_s5    <= abs_s4;
			neg_s5    <= neg_s4;
		end
	end

	// quotient estimate is exact or one short
	always_comb begin
		rem   = abs_s5 - qw_s5;
		q_fix = (rem >= gbc_pkg::SUM_W'(gbc_pkg::WIN_C)) ? q_s5 + 1'b1 : q_s5;
		mean  = neg_s5 ? -$signed(q_fix) : $signed(q_fix);
	end

	always_ff @(posedge clk) begin
		if (pipe.ld_s6) begin
			sample_s6 <= sample_s5;
			stat_s6   <= stat_s5;
			mean_s6   <= mean;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (latch) begin
			offset_q <= mean_s6;
		end
	end

	always_comb begin
		offset_sel = latch ? mean_s6 : offset_q;
		diff       = gbc_pkg::DELTA_W'(sample_s6) - gbc_pkg::DELTA_W'(offset_sel);
		if (diff[gbc_pkg::DELTA_W-1] != diff[gbc_pkg::DELTA_W-2]) begin
			corrected = diff[gbc_pkg::DELTA_W-1] ? gbc_pkg::SAT_MIN : gbc_pkg::SAT_MAX;
		end else begin
			corrected = diff[gbc_pkg::SAMPLE_W-1:0];
		end
	end

	assign stationary = stat_s6;

endmodule

FILE: design/gbc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro bias calibration merge stage
// Combines the per-axis stationarity flags with the settle counter and
// decides when new offsets are latched.
// ----------------------------------------------------------------------------
module gbc_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gbc_pkg::gbc_pipe_t                pipe,
	input  logic                              full,
	input  logic [2:0]                        stat,
	input  logic [gbc_pkg::SETTLE_W-1:0]      settle,
	output logic                              latch
);

	logic [gbc_pkg::CNT_W-1:0] cnt_q;
	logic [gbc_pkg::CNT_W-1:0] settle_ext;
	logic                      fire;

	always_comb begin
		settle_ext = gbc_pkg::CNT_W'(settle);
		fire       = full && (&stat) && (cnt_q >= settle_ext);
		latch      = pipe.ld_out && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (pipe.ld_out) begin
			if (fire) begin
				cnt_q <= '0;
			end else if (cnt_q < settle_ext + 1'b1) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

FILE: design/gyro_bias_calibration_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro bias calibration top level
// Each input passes the lane stage registers and then the output register.
// Throughput: one item per cycle while results.ready does not stall the output;
// set by the update of the running sums in each axis lane on every accepted sample.
// Reset: clears sums, index, fill flag, settle counter, offsets and pipeline
// valids; the window RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module gyro_bias_calibration_top (
	input  logic          clk,
	input  logic          arst_n,
	gbc_sample_if.sink    samples,
	gbc_result_if.source  results,
	gbc_cfg_if.sink       cfg
);

	logic [gbc_pkg::THR_W-1:0]    thr_q;
	logic [gbc_pkg::SETTLE_W-1:0] settle_q;

	logic [gbc_pkg::IDX_W-1:0] idx_q;
	logic                      filled_q;
	logic                      idx_last;

	logic [6:1] stage_valid_q;
	logic [7:2] load;
	logic       rdy_s1;
	logic       accept;
	logic       out_valid_q;
	gbc_pkg::gbc_pipe_t pipe;

	logic old_valid_s1;
	logic full_s1, full_s2, full_s3, full_s4, full_s5, full_s6;

	logic [gbc_pkg::ROW_W-1:0] old_row;
	logic [2:0]                stat;
	logic                      latch;

	logic signed [gbc_pkg::SAMPLE_W-1:0] corr_x, corr_y, corr_z;
	logic signed [gbc_pkg::SAMPLE_W-1:0] corr_x_q, corr_y_q, corr_z_q;
	logic                                updated_q;
	logic                                full_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= gbc_pkg::THR_RESET;
			settle_q <= gbc_pkg::SETTLE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				gbc_pkg::REG_VAR_THRESHOLD: begin
					thr_q <= cfg.data[gbc_pkg::THR_W-1:0];
				end
				gbc_pkg::REG_SETTLE_SAMPLES: begin
					settle_q <= cfg.data[gbc_pkg::SETTLE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// stall chain: a stage loads when the stage after it is empty or moving
	always_comb begin
		load[7] = stage_valid_q[6] && (!out_valid_q || results.ready);
		for (int k = 6; k >= 2; k--) begin
			load[k] = stage_valid_q[k-1] && (!stage_valid_q[k] || load[k+1]);
		end
		rdy_s1 = !stage_valid_q[1] || load[2];
		accept = samples.valid && rdy_s1;
	end

	assign samples.ready = rdy_s1;

	always_comb begin
		pipe.accept = accept;
		pipe.ld_s2  = load[2];
		pipe.ld_s3  = load[3];
		pipe.ld_s4  = load[4];
		pipe.ld_s5  = load[5];
		pipe.ld_s6  = load[6];
		pipe.ld_out = load[7];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (rdy_s1) begin
				stage_valid_q[1] <= accept;
			end
			for (int k = 2; k <= 6; k++) begin
				if (!stage_valid_q[k] || load[k+1]) begin
					stage_valid_q[k] <= load[k];
				end
			end
			if (!out_valid_q || results.ready) begin
				out_valid_q <= load[7];
			end
		end
	end

	assign idx_last = (idx_q == gbc_pkg::IDX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			filled_q <= 1'b0;
		end else if (accept) begin
			if (idx_last) begin
				idx_q    <= '0;
				filled_q <= 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			old_valid_s1 <= filled_q;
			full_s1      <= filled_q || idx_last;
		end
		if (load[2]) begin
			full_s2 <= full_s1;
		end
		if (load[3]) begin
			full_s3 <= full_s2;
		end
		if (load[4]) begin
			full_s4 <= full_s3;
		end
		if (load[5]) begin
			full_s5 <= full_s4;
		end
		if (load[6]) begin
			full_s6 <= full_s5;
		end
	end

	gbc_ram #(
		.WIDTH (gbc_pkg::ROW_W),
		.DEPTH (gbc_pkg::WINDOW)
	) u_window (
		.clk   (clk),
		.we    (accept),
		.waddr (idx_q),
		.wdata ({samples.gyro_z, samples.gyro_y, samples.gyro_x}),
		.re    (accept),
		.raddr (idx_q),
		.rdata (old_row)
	);

	gbc_lane u_lane_x (
		.clk        (clk),
		.arst_n     (arst_n),
		.pipe       (pipe),
		.sample     (samples.gyro_x),
		.old_sample (old_row[0 +: gbc_pkg::SAMPLE_W]),
		.old_valid  (old_valid_s1),
		.threshold  (thr_q),
		.latch      (latch),
		.stationary (stat[0]),
		.corrected  (corr_x)
	);

	gbc_lane u_lane_y (
		.clk        (clk),
		.arst_n     (arst_n),
		.pipe       (pipe),
		.sample     (samples.gyro_y),
		.old_sample (old_row[gbc_pkg::SAMPLE_W +: gbc_pkg::SAMPLE_W]),
		.old_valid  (old_valid_s1),
		.threshold  (thr_q),
		.latch      (latch),
		.stationary (stat[1]),
		.corrected  (corr_y)
	);

	gbc_lane u_lane_z (
		.clk        (clk),
		.arst_n     (arst_n),
		.pipe       (pipe),
		.sample     (samples.gyro_z),
		.old_sample (old_row[2*gbc_pkg::SAMPLE_W +: gbc_pkg::SAMPLE_W]),
		.old_valid  (old_valid_s1),
		.threshold  (thr_q),
		.latch      (latch),
		.stationary (stat[2]),
		.corrected  (corr_z)
	);

	gbc_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.pipe   (pipe),
		.full   (full_s6),
		.stat   (stat),
		.settle (settle_q),
		.latch  (latch)
	);

	always_ff @(posedge clk) begin
		if (load[7]) begin
			corr_x_q  <= corr_x;
			corr_y_q  <= corr_y;
			corr_z_q  <= corr_z;
			updated_q <= latch;
			full_q    <= full_s6;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.corrected_x    = corr_x_q;
	assign results.corrected_y    = corr_y_q;
	assign results.corrected_z    = corr_z_q;
	assign results.offset_updated = updated_q;
	assign results.window_full    = full_q;

	a_filled_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q |=> filled_q)
		else $error("fill flag dropped");

	a_fill_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(filled_q) |-> idx_q == '0)
		else $error("fill flag set without index wrap");

	a_latch_cond: assert property (@(posedge clk) disable iff (!arst_n)
		latch |-> full_s6 && stat == 3'b111 && load[7])
		else $error("offset latch without full stationary window");

	a_update_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && updated_q |-> full_q)
		else $error("offset update reported before window filled");

endmodule
